FILE: hw/rtl/bsmla_pkg.sv
`default_nettype none
package bsmla_pkg;

    localparam int LANES       = 64;
    localparam int PLANES      = 16;
    // plane_index is 4 bits wide, so at most 16 planes can be addressed
    localparam int PLANE_SLOTS = 16;
    localparam int NUM_SLOTS   = (PLANES < PLANE_SLOTS) ? PLANES : PLANE_SLOTS;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_READ = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    typedef logic [LANES-1:0] lane_vec_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  plane_index;
        logic [63:0] lane_mask;
        logic [63:0] operand_plane;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] result_plane;
        logic [63:0] carry_vector;
    } out_beat_t;

    // write request into the plane store
    typedef struct packed {
        logic      we;
        slot_t     slot;
        lane_vec_t plane;
        lane_vec_t ripple;
    } st_wr_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bit_sliced_masked_lane_adder.sv
// Bit-sliced masked lane adder.
//
// Holds LANES unsigned accumulators stored as bit planes. Each input beat on
// in_data carries a command (add, subtract, read), a plane index, a lane mask
// and one operand plane. An add or subtract runs one row of full adders over
// the stored plane and the held carry/borrow vector; plane 0 starts from a
// clear vector. Feed planes LSB first to do a full-width add or subtract.
//
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data, each
// a plain valid/ready handshake; one result beat per input beat, in order.
// Flow: an accepted beat sits in the input register, is computed out of it
// and is registered into the result register behind out_data. One beat per
// cycle while out_ready holds; the input and result registers are each one stage.
// Stall: while out_ready is low and a result waits, the input register can
// still take one beat; in_ready then drops until the result is taken.
// Reset: rst_n (async, active low) clears all planes and the carry vector
// and empties both stages.
`default_nettype none
module bit_sliced_masked_lane_adder
    import bsmla_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_beat_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_beat_t     out_data
);

    in_beat_t  in_reg;
    logic      in_valid_reg;
    out_beat_t out_beat_reg;
    out_beat_t out_beat_next;
    logic      out_valid_reg;
    logic      advance;

    lane_vec_t stored_plane;
    lane_vec_t held_ripple;
    lane_vec_t carry_in;
    lane_vec_t x_plane;
    lane_vec_t row_sum;
    lane_vec_t row_carry;
    logic      plane_ok;
    logic      is_arith;
    st_wr_t    st_wr;

    // input stage moves on when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // planes past the implemented range act as a no-op
    assign plane_ok = 7'(in_reg.plane_index) < 7'(NUM_SLOTS);
    assign is_arith = (in_reg.cmd == CMD_ADD) || (in_reg.cmd == CMD_SUB);

    bsmla_plane_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_slot  (in_reg.plane_index[SLOT_W-1:0]),
        .wr       (st_wr),
        .rd_plane (stored_plane),
        .ripple   (held_ripple)
    );

    // lanes above LANES drop out here; mask gates only the operand bit
    assign x_plane  = in_reg.lane_mask[LANES-1:0] & in_reg.operand_plane[LANES-1:0];
    assign carry_in = (in_reg.plane_index == 4'd0) ? '0 : held_ripple;

    bsmla_adder_row u_row (
        .subtract (in_reg.cmd == CMD_SUB),
        .a        (stored_plane),
        .x        (x_plane),
        .c        (carry_in),
        .sum      (row_sum),
        .carry    (row_carry)
    );

    always_comb
    begin
        st_wr.we     = advance && plane_ok && is_arith;
        st_wr.slot   = in_reg.plane_index[SLOT_W-1:0];
        st_wr.plane  = row_sum;
        st_wr.ripple = row_carry;

        out_beat_next.result_plane = '0;
        out_beat_next.carry_vector = 64'(held_ripple);
        if (plane_ok)
        begin
            if (is_arith)
            begin
                out_beat_next.result_plane = 64'(row_sum);
                out_beat_next.carry_vector = 64'(row_carry);
            end
            else
            begin
                out_beat_next.result_plane = 64'(stored_plane);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input blocked with empty result register");

    a_bad_plane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !plane_ok |=> out_beat_reg.result_plane == 64'd0)
        else $error("out-of-range plane returned nonzero data");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !is_arith |-> !st_wr.we)
        else $error("read command wrote the plane store");

endmodule
`default_nettype wire

FILE: hw/rtl/bsmla_adder_row.sv
`default_nettype none
module bsmla_adder_row
    import bsmla_pkg::*;
(
    input  wire logic      subtract,
    input  wire lane_vec_t a,
    input  wire lane_vec_t x,
    input  wire lane_vec_t c,
    output lane_vec_t      sum,
    output lane_vec_t      carry
);

    lane_vec_t a_eff;

    // borrow uses the complemented minuend in the majority term
    assign a_eff = subtract ? ~a : a;
    assign sum   = a ^ x ^ c;
    assign carry = (a_eff & x) | (a_eff & c) | (x & c);

endmodule
`default_nettype wire

FILE: hw/rtl/bsmla_plane_store.sv
`default_nettype none
module bsmla_plane_store
    import bsmla_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire slot_t  rd_slot,
    input  wire st_wr_t wr,
    output lane_vec_t   rd_plane,
    output lane_vec_t   ripple
);

    lane_vec_t planes_reg [NUM_SLOTS];
    lane_vec_t ripple_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                planes_reg[i] <= '0;
            end
            ripple_reg <= '0;
        end
        else if (wr.we)
        begin
            planes_reg[wr.slot] <= wr.plane;
            ripple_reg          <= wr.ripple;
        end
    end

    assign rd_plane = planes_reg[rd_slot];
    assign ripple   = ripple_reg;

    a_ripple_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !wr.we |=> $stable(ripple_reg))
        else $error("ripple vector changed without a write");

    a_ripple_written: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> ripple_reg == $past(wr.ripple))
        else $error("ripple vector not loaded on write");

endmodule
`default_nettype wire
